[hw/rtl/kwm_pkg.sv]
// Package for the k-way sorted list merger.
// Holds shared widths, defaults, register indexes and the control state type.
// No dependencies.
`default_nettype none

package kwm_pkg;

    // Field widths of the item and result channels
    localparam int VALUE_W = 32;
    localparam int LIST_W  = 2;

    // Default sizing of the list stores
    localparam int DEF_LISTS      = 4;
    localparam int DEF_LIST_DEPTH = 16;

    // Longest merged run emitted for one set
    localparam int MAX_RESULTS = 64;

    // Configuration port
    localparam int          PADDR_W   = 3;
    localparam int          PDATA_W   = 32;
    localparam int          CFG_W     = 3;
    localparam logic [CFG_W-1:0] CFG_LISTS_RESET = 3'd4;
    localparam logic        REG_LISTS_IN_USE = 1'b0;

    // Control sequence: load items, scan list heads, settle pick, emit
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/kwm_store.sv]
// Element store of the k-way merger: one write port, one read port.
// Read data is registered. Uses no package items.
`default_nettype none

module kwm_store #(
    parameter int ENTRIES = 64,
    parameter int ADDR_W  = 6,
    parameter int DATA_W  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/kwm_cfg.sv]
// Configuration register block of the k-way merger (APB-style slave).
// Holds lists_in_use; depends on kwm_pkg for widths and register indexes.
`default_nettype none

module kwm_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kwm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [kwm_pkg::PDATA_W-1:0] pwdata,
    output logic      [kwm_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [kwm_pkg::CFG_W-1:0]   o_lists_in_use
);

    logic                      reg_idx;
    logic [kwm_pkg::CFG_W-1:0] r_lists;
    logic [kwm_pkg::CFG_W-1:0] n_lists;

    assign reg_idx = paddr[kwm_pkg::PADDR_W-1];
    assign pready  = 1'b1;

    always_comb begin
        n_lists = r_lists;
        if (psel && penable && pwrite && (reg_idx == kwm_pkg::REG_LISTS_IN_USE)) begin
            n_lists = pwdata[kwm_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lists <= kwm_pkg::CFG_LISTS_RESET;
        end else begin
            r_lists <= n_lists;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == kwm_pkg::REG_LISTS_IN_USE) begin
            prdata = {{(kwm_pkg::PDATA_W-kwm_pkg::CFG_W){1'b0}}, r_lists};
        end
    end

    assign o_lists_in_use = r_lists;

endmodule

`default_nettype wire

[hw/rtl/k_way_sorted_list_merger.sv]
// k-way sorted list merger: per-list element stores and a head-scan merge.
// Depends on kwm_pkg, kwm_store and kwm_cfg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one element per item,
//   tagged with its list number. Items load at one per cycle; each goes to
//   slot fill_count of its list in the element store. Elements for lists at
//   or above lists_in_use (0 acts as 1), or for a full list, are dropped and
//   set a sticky overflow flag. The end_of_set item is handled alike and
//   starts the merge unless the set is empty; o_in_ready stays low until the
//   merged run is fully handed to the output register.
//   Output channel (o_out_valid / i_out_ready) carries one merged element
//   per item, with its source list, a last-of-run mark and the overflow flag.
//   Merge steps: for every result, each list head is read in turn through
//   the single store read port, ST_LAST settles the last compare, and
//   ST_EMIT moves the pick into the output register.
//   Ties go to the lower list number; empty lists are skipped; at most
//   MAX_RESULTS elements are emitted per set.
//   A stalled receiver holds the output register; the pick then waits in
//   the emit step. The last result may sit in the output register while
//   the next set is already loading.
//   Reset clears fill counts, read positions, the overflow flag and all
//   control; the element store needs no clearing since only filled slots
//   are read. lists_in_use resets to 4 and is written through the APB port
//   at byte address 0.
`default_nettype none

module k_way_sorted_list_merger #(
    parameter int LISTS      = kwm_pkg::DEF_LISTS,
    parameter int LIST_DEPTH = kwm_pkg::DEF_LIST_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // item input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic        [kwm_pkg::LIST_W-1:0]  i_list_number,
    input  wire logic signed [kwm_pkg::VALUE_W-1:0] i_element_value,
    input  wire logic                               i_end_of_set,
    // merged output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [kwm_pkg::VALUE_W-1:0] o_merged_value,
    output logic             [kwm_pkg::LIST_W-1:0]  o_source_list,
    output logic                                    o_last_of_run,
    output logic                                    o_overflow_seen,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [kwm_pkg::PADDR_W-1:0] paddr,
    input  wire logic        [kwm_pkg::PDATA_W-1:0] pwdata,
    output logic             [kwm_pkg::PDATA_W-1:0] prdata,
    output logic                                    pready
);

    localparam int ENTRIES = LISTS * LIST_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int LN_W    = $clog2(LISTS);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int TOT_W   = $clog2(ENTRIES + 1);
    localparam int REM_W   = $clog2(kwm_pkg::MAX_RESULTS + 1);
    localparam int VW      = kwm_pkg::VALUE_W;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic [kwm_pkg::CFG_W-1:0] lists_in_use;

    kwm_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_lists_in_use (lists_in_use)
    );

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    kwm_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]  r_fill [LISTS];
    logic [CNT_W-1:0]  n_fill [LISTS];
    logic [CNT_W-1:0]  r_pos  [LISTS];
    logic [CNT_W-1:0]  n_pos  [LISTS];
    logic              r_drop, n_drop;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [REM_W-1:0]  r_remain, n_remain;

    // head scan: issue stage
    logic [LN_W-1:0]   r_k, n_k;
    logic [ADDR_W-1:0] r_base, n_base;
    // head scan: compare stage (store data arrives in the cycle after issue)
    logic              r_pend_v, n_pend_v;
    logic              r_pend_cand, n_pend_cand;
    logic [LN_W-1:0]   r_pend_idx, n_pend_idx;
    // running pick
    logic              r_found, n_found;
    logic [LN_W-1:0]   r_best, n_best;
    logic signed [VW-1:0] r_best_val, n_best_val;

    // output register
    logic              r_out_v, n_out_v;
    logic signed [VW-1:0] r_out_val, n_out_val;
    logic [kwm_pkg::LIST_W-1:0] r_out_src, n_out_src;
    logic              r_out_last, n_out_last;
    logic              r_out_ovf, n_out_ovf;

    // ---------------------------------------------------------------------
    // Element store
    // ---------------------------------------------------------------------
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [VW-1:0]        mem_rdata;
    logic signed [VW-1:0] head_val;

    kwm_store #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W),
        .DATA_W  (VW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_element_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign head_val = $signed(mem_rdata);

    // Read the head of the list under scan
    assign mem_raddr = r_base + ADDR_W'(r_pos[r_k]);

    // ---------------------------------------------------------------------
    // Load decode
    // ---------------------------------------------------------------------
    int              cfg_lists;
    int              eff_lists;
    logic [LN_W-1:0] ln_idx;
    logic [LN_W-1:0] sel_idx;
    logic [CNT_W-1:0] fill_sel;
    logic            in_use;
    logic            load_ok;
    logic            in_accept;
    logic [TOT_W-1:0] tot_after;
    logic            emit_go;

    always_comb begin
        cfg_lists = int'(lists_in_use);
        if (cfg_lists < 1) begin
            eff_lists = 1;
        end else if (cfg_lists > LISTS) begin
            eff_lists = LISTS;
        end else begin
            eff_lists = cfg_lists;
        end
    end

    assign ln_idx    = LN_W'(i_list_number);
    assign sel_idx   = (r_state == kwm_pkg::ST_LOAD) ? ln_idx : r_k;
    assign fill_sel  = r_fill[sel_idx];
    assign in_use    = int'(i_list_number) < eff_lists;
    assign load_ok   = in_use && (fill_sel < CNT_W'(LIST_DEPTH));
    assign o_in_ready = (r_state == kwm_pkg::ST_LOAD);
    assign in_accept = i_in_valid && o_in_ready;
    assign tot_after = load_ok ? (r_total + TOT_W'(1)) : r_total;

    assign mem_we    = in_accept && load_ok;
    assign mem_waddr = ADDR_W'(int'(ln_idx) * LIST_DEPTH + int'(fill_sel));

    assign emit_go   = (r_state == kwm_pkg::ST_EMIT) && (!r_out_v || i_out_ready);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_drop      = r_drop;
        n_total     = r_total;
        n_remain    = r_remain;
        n_k         = r_k;
        n_base      = r_base;
        n_pend_v    = 1'b0;
        n_pend_cand = r_pend_cand;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_val  = r_best_val;
        n_out_v     = r_out_v && !i_out_ready;
        n_out_val   = r_out_val;
        n_out_src   = r_out_src;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        // Compare stage: keep strictly smaller heads so ties stay on the lower list
        if (r_pend_v && r_pend_cand && (!r_found || (head_val < r_best_val))) begin
            n_found    = 1'b1;
            n_best     = r_pend_idx;
            n_best_val = head_val;
        end

        case (r_state)
            kwm_pkg::ST_LOAD: begin
                if (in_accept) begin
                    if (load_ok) begin
                        n_fill[ln_idx] = fill_sel + CNT_W'(1);
                        n_total        = tot_after;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_end_of_set) begin
                        if (tot_after == '0) begin
                            // Empty set: drop everything, no result
                            n_drop  = 1'b0;
                            n_total = '0;
                            for (int i = 0; i < LISTS; i++) begin
                                n_fill[i] = '0;
                                n_pos[i]  = '0;
                            end
                        end else begin
                            if (int'(tot_after) > kwm_pkg::MAX_RESULTS) begin
                                n_remain = REM_W'(kwm_pkg::MAX_RESULTS);
                            end else begin
                                n_remain = REM_W'(tot_after);
                            end
                            n_state = kwm_pkg::ST_SCAN;
                            n_k     = '0;
                            n_base  = '0;
                            n_found = 1'b0;
                        end
                    end
                end
            end
            kwm_pkg::ST_SCAN: begin
                // Issue the head read of list r_k
                n_pend_v    = 1'b1;
                n_pend_cand = r_pos[r_k] < fill_sel;
                n_pend_idx  = r_k;
                if (r_k == LN_W'(LISTS - 1)) begin
                    n_state = kwm_pkg::ST_LAST;
                end else begin
                    n_k    = r_k + LN_W'(1);
                    n_base = r_base + ADDR_W'(LIST_DEPTH);
                end
            end
            kwm_pkg::ST_LAST: begin
                n_state = kwm_pkg::ST_EMIT;
            end
            kwm_pkg::ST_EMIT: begin
                if (emit_go) begin
                    if (r_found) begin
                        n_out_v       = 1'b1;
                        n_out_val     = r_best_val;
                        n_out_src     = kwm_pkg::LIST_W'(r_best);
                        n_out_last    = (r_remain == REM_W'(1));
                        n_out_ovf     = r_drop;
                        n_pos[r_best] = r_pos[r_best] + CNT_W'(1);
                        n_remain      = r_remain - REM_W'(1);
                    end
                    if (!r_found || (r_remain == REM_W'(1))) begin
                        // Run done: clear the set for the next load
                        n_state  = kwm_pkg::ST_LOAD;
                        n_drop   = 1'b0;
                        n_total  = '0;
                        n_remain = '0;
                        for (int i = 0; i < LISTS; i++) begin
                            n_fill[i] = '0;
                            n_pos[i]  = '0;
                        end
                    end else begin
                        n_state = kwm_pkg::ST_SCAN;
                        n_k     = '0;
                        n_base  = '0;
                        n_found = 1'b0;
                    end
                end
            end
            default: begin
                n_state = kwm_pkg::ST_LOAD;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kwm_pkg::ST_LOAD;
            r_drop   <= 1'b0;
            r_total  <= '0;
            r_remain <= '0;
            r_k      <= '0;
            r_base   <= '0;
            r_pend_v <= 1'b0;
            r_found  <= 1'b0;
            r_out_v  <= 1'b0;
            for (int i = 0; i < LISTS; i++) begin
                r_fill[i] <= '0;
                r_pos[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_drop   <= n_drop;
            r_total  <= n_total;
            r_remain <= n_remain;
            r_k      <= n_k;
            r_base   <= n_base;
            r_pend_v <= n_pend_v;
            r_found  <= n_found;
            r_out_v  <= n_out_v;
            r_fill   <= n_fill;
            r_pos    <= n_pos;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_pend_cand <= n_pend_cand;
        r_pend_idx  <= n_pend_idx;
        r_best      <= n_best;
        r_best_val  <= n_best_val;
        r_out_val   <= n_out_val;
        r_out_src   <= n_out_src;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid     = r_out_v;
    assign o_merged_value  = r_out_val;
    assign o_source_list   = r_out_src;
    assign o_last_of_run   = r_out_last;
    assign o_overflow_seen = r_out_ovf;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_remain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kwm_pkg::ST_LOAD) |-> (r_remain != '0))
        else $error("merge running with no results left");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kwm_pkg::ST_EMIT) |-> r_found)
        else $error("emit step reached without a candidate head");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && (r_remain == REM_W'(1))) |=>
            ((r_state == kwm_pkg::ST_LOAD) && (r_total == '0) && !r_drop))
        else $error("set not cleared after last result");

endmodule

`default_nettype wire

[tb/k_way_sorted_list_merger_test.sv]
// Self-checking testbench for the k-way sorted list merger.
// Holds a merge predictor, item and APB drivers, a result checker and the tests.
// Depends on kwm_pkg and k_way_sorted_list_merger.
`default_nettype none

module k_way_sorted_list_merger_test;

    localparam int LISTS       = kwm_pkg::DEF_LISTS;
    localparam int LIST_DEPTH  = kwm_pkg::DEF_LIST_DEPTH;
    localparam int VALUE_W     = kwm_pkg::VALUE_W;
    localparam int LIST_W      = kwm_pkg::LIST_W;
    localparam int PADDR_W     = kwm_pkg::PADDR_W;
    localparam int PDATA_W     = kwm_pkg::PDATA_W;
    localparam int CFG_W       = kwm_pkg::CFG_W;
    localparam int MAX_RESULTS = kwm_pkg::MAX_RESULTS;

    // Cycles to let the block settle after the last merged item.
    localparam int SETTLE_CYCLES  = 2 * (LISTS + 3);
    localparam int RANDOM_ITEMS   = 185;
    localparam int TAIL_ITEMS     = 40;
    localparam int TIMEOUT_CYCLES = 300000;

    localparam logic [PADDR_W-1:0] ADDR_LISTS_IN_USE =
        PADDR_W'(4 * int'(kwm_pkg::REG_LISTS_IN_USE));

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic        [LIST_W-1:0]  src;
        logic                      last;
        logic                      ovf;
    } t_merged;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic        [LIST_W-1:0]    i_list_number = '0;
    logic signed [VALUE_W-1:0]   i_element_value = '0;
    logic                        i_end_of_set = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [VALUE_W-1:0]   o_merged_value;
    logic        [LIST_W-1:0]    o_source_list;
    logic                        o_last_of_run;
    logic                        o_overflow_seen;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic        [PADDR_W-1:0]   paddr = '0;
    logic        [PDATA_W-1:0]   pwdata = '0;
    logic        [PDATA_W-1:0]   prdata;
    logic                        pready;

    // Predictor state: per-list stores, fill and read counts, drop flag
    logic signed [VALUE_W-1:0]   list_store [LISTS][LIST_DEPTH];
    int unsigned                 list_fill [LISTS];
    int unsigned                 list_pos [LISTS];
    bit                          set_dropped;
    logic        [CFG_W-1:0]     cfg_lists = kwm_pkg::CFG_LISTS_RESET;

    t_merged                     pending_merged [$];
    int unsigned                 mismatch_count = 0;
    int unsigned                 items_sent = 0;
    bit                          tail_phase = 1'b0;
    int unsigned                 stall_left = 0;
    int unsigned                 calm_left = 0;

    k_way_sorted_list_merger #(
        .LISTS      (LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_list_number   (i_list_number),
        .i_element_value (i_element_value),
        .i_end_of_set    (i_end_of_set),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_merged_value  (o_merged_value),
        .o_source_list   (o_source_list),
        .o_last_of_run   (o_last_of_run),
        .o_overflow_seen (o_overflow_seen),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned active_lists();
        int unsigned n;
        n = cfg_lists;
        if (n < 1) n = 1;
        if (n > LISTS) n = LISTS;
        return n;
    endfunction

    function automatic void clear_set();
        for (int l = 0; l < LISTS; l++) begin
            list_fill[l] = 0;
            list_pos[l]  = 0;
        end
        set_dropped = 1'b0;
    endfunction

    // Store one accepted item; on end of set queue the whole merged run.
    function automatic void load_and_merge(input logic [LIST_W-1:0] list,
                                           input logic signed [VALUE_W-1:0] value,
                                           input logic eos);
        int unsigned               total;
        int unsigned               best;
        bit                        found;
        logic signed [VALUE_W-1:0] best_value;
        t_merged                   r;
        if (list < active_lists() && list_fill[list] < LIST_DEPTH) begin
            list_store[list][list_fill[list]] = value;
            list_fill[list]++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!eos) return;
        total = 0;
        for (int l = 0; l < LISTS; l++) total += list_fill[l];
        if (total > MAX_RESULTS) total = MAX_RESULTS;
        for (int unsigned n = 0; n < total; n++) begin
            found      = 1'b0;
            best       = 0;
            best_value = '0;
            // strict less-than keeps ties on the lower list number
            for (int l = 0; l < LISTS; l++) begin
                if (list_pos[l] < list_fill[l]) begin
                    if (!found || list_store[l][list_pos[l]] < best_value) begin
                        found      = 1'b1;
                        best       = l;
                        best_value = list_store[l][list_pos[l]];
                    end
                end
            end
            if (!found) break;
            list_pos[best]++;
            r.value = best_value;
            r.src   = LIST_W'(best);
            r.last  = (n + 1 == total);
            r.ovf   = set_dropped;
            pending_merged = {pending_merged, r};
        end
        clear_set();
    endfunction

    // Receiver: stall in random bursts, with calm stretches; never in the tail.
    always @(posedge i_clk) begin
        if (tail_phase) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left   <= calm_left - 1;
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left   <= $urandom_range(30, 80);
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every merged item against the oldest expectation.
    always @(posedge i_clk) begin : merged_check
        t_merged exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_merged.size() == 0) begin
                $error("unexpected merged item: value %0d from list %0d",
                       o_merged_value, o_source_list);
                mismatch_count++;
            end else begin
                exp_r = pending_merged.pop_front();
                if (o_merged_value !== exp_r.value) begin
                    $error("merged_value: expected %0d, got %0d", exp_r.value, o_merged_value);
                    mismatch_count++;
                end
                if (o_source_list !== exp_r.src) begin
                    $error("source_list: expected %0d, got %0d", exp_r.src, o_source_list);
                    mismatch_count++;
                end
                if (o_last_of_run !== exp_r.last) begin
                    $error("last_of_run: expected %0b, got %0b", exp_r.last, o_last_of_run);
                    mismatch_count++;
                end
                if (o_overflow_seen !== exp_r.ovf) begin
                    $error("overflow_seen: expected %0b, got %0b", exp_r.ovf, o_overflow_seen);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one item, after an optional idle burst; hold valid until accepted.
    task automatic send_item(input logic [LIST_W-1:0] list,
                             input logic signed [VALUE_W-1:0] value,
                             input logic eos);
        int unsigned gap;
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_list_number   <= list;
        i_element_value <= value;
        i_end_of_set    <= eos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        load_and_merge(list, value, eos);
    endtask

    // Drop valid and hold until every expected item has come and the block is idle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_merged.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lists_in_use(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LISTS_IN_USE;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_lists = value;
        @(posedge i_clk);
    endtask

    task automatic check_lists_in_use();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LISTS_IN_USE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== PDATA_W'(cfg_lists)) begin
            $error("lists_in_use: expected %0d, got %0d", cfg_lists, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_register();
        check_lists_in_use();
    endtask

    // Extremes of the value range and a three-way tie across lists.
    task automatic test_ties_and_extremes();
        send_item(2'd0, 32'sh8000_0000, 1'b0);
        send_item(2'd1, 32'sd5, 1'b0);
        send_item(2'd0, 32'sd5, 1'b0);
        send_item(2'd2, 32'sd5, 1'b0);
        send_item(2'd3, 32'sh7fff_ffff, 1'b1);
        wait_drained();
    endtask

    // A zero register acts as one list; values above four act as four.
    task automatic test_register_extremes();
        write_lists_in_use(3'd0);
        check_lists_in_use();
        send_item(2'd1, 32'sd9, 1'b0);
        send_item(2'd0, -32'sd1, 1'b1);
        wait_drained();
        write_lists_in_use(3'd7);
        check_lists_in_use();
        send_item(2'd3, -32'sd7, 1'b1);
        wait_drained();
    endtask

    // A set with nothing stored gives no item and loses its drop mark.
    task automatic test_empty_set();
        write_lists_in_use(3'd2);
        send_item(2'd2, 32'sd44, 1'b1);
        wait_drained();
        send_item(2'd0, 32'sd1, 1'b1);
        wait_drained();
    endtask

    // Narrow the register while elements of lists 3 and 1 are already held.
    task automatic test_mid_set_change();
        write_lists_in_use(3'd4);
        send_item(2'd3, 32'sd10, 1'b0);
        send_item(2'd1, 32'sd20, 1'b0);
        wait_drained();
        write_lists_in_use(3'd1);
        send_item(2'd0, 32'sd30, 1'b1);
        wait_drained();
    endtask

    // Fill list 0 completely; the end-of-set element overflows and is dropped.
    task automatic test_full_list();
        for (int k = 0; k < LIST_DEPTH; k++) send_item(2'd0, VALUE_W'(k - 8), 1'b0);
        send_item(2'd0, 32'sd100, 1'b1);
        wait_drained();
    endtask

    // One well-formed set with random sizes and content, plus some noise.
    task automatic send_random_set();
        int unsigned               remaining [LISTS];
        longint                    next_value [LISTS];
        int unsigned               left;
        int unsigned               n_active;
        bit                        tie_mode;
        logic        [LIST_W-1:0]  pick;
        logic signed [VALUE_W-1:0] value;
        n_active = active_lists();
        tie_mode = ($urandom_range(0, 3) == 0);
        left     = 0;
        for (int l = 0; l < LISTS; l++) begin
            if (l >= n_active) remaining[l] = ($urandom_range(0, 4) == 0) ? 1 : 0;
            else if ($urandom_range(0, 14) == 0) remaining[l] = $urandom_range(15, 17);
            else remaining[l] = $urandom_range(0, 5);
            if (tie_mode) next_value[l] = longint'($urandom_range(0, 6)) - 3;
            else next_value[l] = longint'($signed($urandom()));
            left += remaining[l];
        end
        if (left == 0) begin
            send_item(LIST_W'($urandom_range(0, LISTS - 1)), $urandom(), 1'b1);
            items_sent++;
            return;
        end
        while (left != 0) begin
            do pick = LIST_W'($urandom_range(0, LISTS - 1)); while (remaining[pick] == 0);
            remaining[pick]--;
            left--;
            if ($urandom_range(0, 19) == 0) begin
                value = $urandom();   // out-of-order element
            end else begin
                value = VALUE_W'(next_value[pick]);
                if (tie_mode) next_value[pick] += $urandom_range(0, 1);
                else next_value[pick] += longint'($urandom() >> $urandom_range(1, 31));
                if (next_value[pick] > 64'sd2147483647) next_value[pick] = 64'sd2147483647;
            end
            send_item(pick, value, left == 0);
            items_sent++;
        end
    endtask

    task automatic test_random_sets();
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                write_lists_in_use(CFG_W'($urandom_range(0, 7)));
            end
            send_random_set();
        end
        wait_drained();
    endtask

    initial begin
        clear_set();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_register();
        test_ties_and_extremes();
        test_register_extremes();
        test_empty_set();
        test_mid_set_change();
        test_full_list();
        test_random_sets();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 4);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_store.sv
hw/rtl/kwm_cfg.sv
hw/rtl/k_way_sorted_list_merger.sv
tb/k_way_sorted_list_merger_test.sv
